[design/ccte_pkg.sv]
// shared types, constants and helpers for the carriage control tape engine
`timescale 1ns / 1ps

package ccte_pkg;

  localparam int TAPE_DEPTH_DEF = 132;

  localparam int PUNCH_W = 13;
  localparam int SUM_W   = 9;

  localparam logic [7:0]         LENGTH_RST  = 8'd66;
  localparam logic [PUNCH_W-1:0] FIRST_ENTRY = 13'd3;
  localparam logic [3:0]         TOP_CHANNEL = 4'd12;
  localparam logic [3:0]         NINE_CHANNEL = 4'd9;
  localparam logic [3:0]         MAX_SPACE   = 4'd3;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CMD   = 2'd1;
  localparam logic [1:0] OP_PRINT = 2'd2;

  localparam logic [1:0] KIND_SKIP_NOW   = 2'd0;
  localparam logic [1:0] KIND_SPACE_AFTER = 2'd1;
  localparam logic [1:0] KIND_SPACE_NOW  = 2'd2;
  localparam logic [1:0] KIND_SKIP_AFTER = 2'd3;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [SUM_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic punched(logic [PUNCH_W-1:0] mask, logic [3:0] ch);
    logic [PUNCH_W-1:0] sh;
    sh = mask >> ch;
    return sh[0];
  endfunction

endpackage

[design/ccte_mod_unit.sv]
// iterative restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module ccte_mod_unit import ccte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam logic [CNT_W-1:0] STEP_CNT = CNT_W'(SUM_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] dvd_r;
  logic [SUM_W-1:0] dvs_r;
  logic [SUM_W-1:0] rem_r;

  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;
  logic [SUM_W-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[SUM_W-1]};
    diff  = trial - {1'b0, dvs_r};
    // partial remainder stays below the divisor, so it fits the narrow width
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = diff[SUM_W-1:0];
    end else begin
      rem_nxt = trial[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_CNT;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[SUM_W-2:0], 1'b0};
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

[design/ccte_tape_mem.sv]
// tape store: single write port, registered read, per-entry valid bits
`timescale 1ns / 1ps

module ccte_tape_mem import ccte_pkg::*; #(
  parameter int DEPTH = TAPE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [PUNCH_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [PUNCH_W-1:0] rdata
);

  logic [PUNCH_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   valid_r;
  logic [PUNCH_W-1:0] rd_r;
  logic               rvld_r;
  logic               rzero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r    <= mem[raddr];
    rvld_r  <= valid_r[raddr];
    rzero_r <= (raddr == '0);
  end

  // unwritten entries read as the power-on tape
  assign rdata = rvld_r ? rd_r : (rzero_r ? FIRST_ENTRY : '0);

endmodule

[design/carriage_control_tape_engine_core.sv]
// carriage control tape engine: sequencer, tape store and shared remainder unit
//
//   channel  dir  ports                       contents
//   in       in   in_tvalid/tready/tdata/tuser one command, load or print-done
//   out      out  out_tvalid/tready/tdata     one result per input transfer
//   cfg      in   cfg_we/cfg_wdata            tape length register
//
// load and no-op items go straight from dispatch to the output state; a space or print
// advance waits on the shared remainder unit and then on a tape read; a channel skip
// waits on it too, then sweeps up to n entries, n the tape length in use, one entry a cycle.
// one item at a time: in_tready is high only while the sequencer is idle.
// a result waits in the output register while the next item is taken.
// reset is synchronous; the tape reads as its power-on contents until written.
`timescale 1ns / 1ps

module carriage_control_tape_engine_core import ccte_pkg::*; #(
  parameter int TAPE_DEPTH = TAPE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // modifier[5:0], suppress_advance[6], tape_index[14:7], tape_punches[27:15]
  input  logic [31:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // lines_advanced[7:0], form_feed[8], overprint[9], channel9_flag[10],
  // channel12_flag[11], status[12]
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int AW = $clog2(TAPE_DEPTH);
  localparam int CW = $clog2(TAPE_DEPTH + 2);
  localparam logic [SUM_W-1:0] DEPTH_W = SUM_W'(TAPE_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_ADV_RD = 3'd4;
  localparam logic [2:0] S_ADV    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  // item registers
  logic [1:0]         op_r;
  logic [1:0]         kind_r;
  logic [3:0]         val_r;
  logic               sup_r;
  logic [7:0]         idx_r;
  logic [PUNCH_W-1:0] punch_r;

  logic [2:0]    state_r, state_nxt;
  logic [7:0]    len_r;
  logic [AW-1:0] position_r, position_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic          pskip_r, pskip_nxt;
  logic          ind9_r, ind9_nxt;
  logic          ind12_r, ind12_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          chk_valid_r, chk_valid_nxt;

  logic          skip_now_r, skip_now_nxt;
  logic          sweep_r, sweep_nxt;
  logic [7:0]    adv_cnt_r, adv_cnt_nxt;
  logic          adv_skip_r, adv_skip_nxt;
  logic [AW-1:0] newpos_r, newpos_nxt;
  logic [AW-1:0] sw_addr_r, sw_addr_nxt;
  logic [CW-1:0] sw_dist_r, sw_dist_nxt;
  logic [CW-1:0] chk_dist_r, chk_dist_nxt;
  logic [AW-1:0] chk_addr_r, chk_addr_nxt;
  logic [7:0]    res_lines_r, res_lines_nxt;
  logic          res_ff_r, res_ff_nxt;
  logic          res_op_r, res_op_nxt;
  logic          res_stat_r, res_stat_nxt;
  logic [15:0]   out_data_r, out_data_nxt;

  logic [SUM_W-1:0]   len_w;
  logic [SUM_W-1:0]   used_w;
  logic [CW-1:0]      used_n;
  logic               in_xfer;
  logic               chan_ok;
  logic               mem_we;
  logic [AW-1:0]      mem_raddr;
  logic [PUNCH_W-1:0] rdata;
  mod_req_t           mod_req;
  mod_rsp_t           mod_rsp;

  ccte_tape_mem #(.DEPTH(TAPE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (idx_r[AW-1:0]),
    .wdata (punch_r),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  ccte_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  // tape length in use, clamped to 1..TAPE_DEPTH
  always_comb begin
    len_w = {1'b0, len_r};
    if (len_w == '0) begin
      used_w = SUM_W'(1);
    end else if (len_w > DEPTH_W) begin
      used_w = DEPTH_W;
    end else begin
      used_w = len_w;
    end
    used_n = used_w[CW-1:0];
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign chan_ok   = (val_r != 4'd0) && (val_r <= TOP_CHANNEL);
  assign mem_we    = (state_r == S_DISP) && (op_r == OP_LOAD) &&
                     ({1'b0, idx_r} < DEPTH_W);

  always_comb begin
    unique case (state_r)
      S_SWEEP:  mem_raddr = sw_addr_r;
      S_ADV_RD: mem_raddr = newpos_r;
      default:  mem_raddr = position_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    position_nxt  = position_r;
    pend_nxt      = pend_r;
    pskip_nxt     = pskip_r;
    ind9_nxt      = ind9_r;
    ind12_nxt     = ind12_r;
    out_valid_nxt = out_valid_r && !out_tready;
    chk_valid_nxt = chk_valid_r;
    skip_now_nxt  = skip_now_r;
    sweep_nxt     = sweep_r;
    adv_cnt_nxt   = adv_cnt_r;
    adv_skip_nxt  = adv_skip_r;
    newpos_nxt    = newpos_r;
    sw_addr_nxt   = sw_addr_r;
    sw_dist_nxt   = sw_dist_r;
    chk_dist_nxt  = chk_dist_r;
    chk_addr_nxt  = chk_addr_r;
    res_lines_nxt = res_lines_r;
    res_ff_nxt    = res_ff_r;
    res_op_nxt    = res_op_r;
    res_stat_nxt  = res_stat_r;
    out_data_nxt  = out_data_r;
    mod_req.start    = 1'b0;
    mod_req.dividend = SUM_W'(position_r) + SUM_W'(1);
    mod_req.divisor  = used_w;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        res_lines_nxt = '0;
        res_ff_nxt    = 1'b0;
        res_op_nxt    = 1'b0;
        res_stat_nxt  = 1'b0;
        state_nxt     = S_OUT;
        if (op_r == OP_CMD) begin
          unique case (kind_r)
            KIND_SKIP_NOW: begin
              // rdata holds the current line here
              if (chan_ok && !punched(rdata, val_r)) begin
                mod_req.start = 1'b1;
                skip_now_nxt  = 1'b1;
                sweep_nxt     = 1'b1;
                state_nxt     = S_MOD;
              end
            end
            KIND_SPACE_AFTER: begin
              if (val_r <= MAX_SPACE) begin
                pend_nxt  = 8'(val_r);
                pskip_nxt = 1'b0;
                ind9_nxt  = 1'b0;
                ind12_nxt = 1'b0;
              end
            end
            KIND_SPACE_NOW: begin
              if (val_r <= MAX_SPACE) begin
                mod_req.start    = 1'b1;
                mod_req.dividend = SUM_W'(position_r) + SUM_W'(val_r);
                adv_cnt_nxt      = 8'(val_r);
                adv_skip_nxt     = 1'b0;
                sweep_nxt        = 1'b0;
                state_nxt        = S_MOD;
              end
            end
            default: begin
              if (chan_ok) begin
                ind9_nxt      = 1'b0;
                ind12_nxt     = 1'b0;
                mod_req.start = 1'b1;
                skip_now_nxt  = 1'b0;
                sweep_nxt     = 1'b1;
                state_nxt     = S_MOD;
              end
            end
          endcase
        end else if (op_r == OP_PRINT) begin
          pend_nxt  = '0;
          pskip_nxt = 1'b0;
          if (pend_r != '0) begin
            mod_req.start    = 1'b1;
            mod_req.dividend = SUM_W'(position_r) + SUM_W'(pend_r);
            adv_cnt_nxt      = pend_r;
            adv_skip_nxt     = pskip_r;
            sweep_nxt        = 1'b0;
            state_nxt        = S_MOD;
          end else if (!sup_r) begin
            mod_req.start    = 1'b1;
            mod_req.dividend = SUM_W'(position_r) + SUM_W'(1);
            adv_cnt_nxt      = 8'd1;
            adv_skip_nxt     = 1'b0;
            sweep_nxt        = 1'b0;
            state_nxt        = S_MOD;
          end else begin
            res_op_nxt = 1'b1;
          end
        end
      end

      S_MOD: begin
        if (mod_rsp.done) begin
          if (sweep_r) begin
            sw_addr_nxt   = mod_rsp.rem[AW-1:0];
            sw_dist_nxt   = CW'(1);
            chk_valid_nxt = 1'b0;
            state_nxt     = S_SWEEP;
          end else begin
            newpos_nxt = mod_rsp.rem[AW-1:0];
            state_nxt  = S_ADV_RD;
          end
        end
      end

      S_SWEEP: begin
        // reads run one entry ahead of the punch check
        if (sw_dist_r <= used_n) begin
          chk_valid_nxt = 1'b1;
          chk_dist_nxt  = sw_dist_r;
          chk_addr_nxt  = sw_addr_r;
          sw_addr_nxt   = (CW'(sw_addr_r) == used_n - CW'(1)) ? '0 : sw_addr_r + 1'b1;
          sw_dist_nxt   = sw_dist_r + 1'b1;
        end else begin
          chk_valid_nxt = 1'b0;
        end
        if (chk_valid_r) begin
          if (punched(rdata, val_r)) begin
            chk_valid_nxt = 1'b0;
            state_nxt     = S_OUT;
            if (skip_now_r) begin
              position_nxt  = chk_addr_r;
              res_lines_nxt = 8'(chk_dist_r);
              res_ff_nxt    = rdata[0];
              ind9_nxt      = rdata[NINE_CHANNEL];
              ind12_nxt     = rdata[TOP_CHANNEL];
            end else begin
              pend_nxt  = 8'(chk_dist_r);
              pskip_nxt = 1'b1;
            end
          end else if (chk_dist_r == used_n) begin
            // runaway: channel not punched anywhere
            chk_valid_nxt = 1'b0;
            res_stat_nxt  = 1'b1;
            state_nxt     = S_OUT;
          end
        end
      end

      S_ADV_RD: begin
        state_nxt = S_ADV;
      end

      S_ADV: begin
        position_nxt  = newpos_r;
        res_lines_nxt = adv_cnt_r;
        res_ff_nxt    = adv_skip_r && rdata[0];
        ind9_nxt      = rdata[NINE_CHANNEL];
        ind12_nxt     = rdata[TOP_CHANNEL];
        state_nxt     = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {3'b000, res_stat_r, ind12_r, ind9_r, res_op_r, res_ff_r,
                           res_lines_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LENGTH_RST;
      position_r  <= '0;
      pend_r      <= '0;
      pskip_r     <= 1'b0;
      ind9_r      <= 1'b0;
      ind12_r     <= 1'b0;
      out_valid_r <= 1'b0;
      chk_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      position_r  <= position_nxt;
      pend_r      <= pend_nxt;
      pskip_r     <= pskip_nxt;
      ind9_r      <= ind9_nxt;
      ind12_r     <= ind12_nxt;
      out_valid_r <= out_valid_nxt;
      chk_valid_r <= chk_valid_nxt;
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r    <= in_tuser;
      val_r   <= in_tdata[3:0];
      kind_r  <= in_tdata[5:4];
      sup_r   <= in_tdata[6];
      idx_r   <= in_tdata[14:7];
      punch_r <= in_tdata[27:15];
    end
    skip_now_r  <= skip_now_nxt;
    sweep_r     <= sweep_nxt;
    adv_cnt_r   <= adv_cnt_nxt;
    adv_skip_r  <= adv_skip_nxt;
    newpos_r    <= newpos_nxt;
    sw_addr_r   <= sw_addr_nxt;
    sw_dist_r   <= sw_dist_nxt;
    chk_dist_r  <= chk_dist_nxt;
    chk_addr_r  <= chk_addr_nxt;
    res_lines_r <= res_lines_nxt;
    res_ff_r    <= res_ff_nxt;
    res_op_r    <= res_op_nxt;
    res_stat_r  <= res_stat_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_DISP))
    else $error("accepted item not dispatched");

  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == S_MOD))
    else $error("remainder result outside wait state");

  a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ({1'b0, CW'(position_r)} < {1'b0, CW'(TAPE_DEPTH)}))
    else $error("tape position beyond depth");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SWEEP) && chk_valid_r) |-> (chk_dist_r <= used_n))
    else $error("sweep ran past tape length");
`endif

endmodule
